// ===== hdl/tks_pkg.sv =====
// shared types and constants of the token scanner
// no dependencies; imported by tks_core, token_scanner, the checker and the testbench
`timescale 1ns / 1ps

package tks_pkg;

	// default widths of the position and offset counters
	localparam int unsigned POSITION_BITS_DEF = 16;
	localparam int unsigned OFFSET_BITS_DEF   = 32;

	// result buffer entries, a power of two
	localparam int unsigned TOKEN_FIFO_DEPTH = 4;

	localparam int unsigned KIND_BITS  = 4;
	localparam int unsigned VALUE_BITS = 32;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_NUM  = 2'd2
	} run_mode_t;

	typedef logic [KIND_BITS-1:0] kind_t;

	localparam kind_t KIND_SEMI     = 4'd0;
	localparam kind_t KIND_LBRACE   = 4'd1;
	localparam kind_t KIND_RBRACE   = 4'd2;
	localparam kind_t KIND_LPAREN   = 4'd3;
	localparam kind_t KIND_RPAREN   = 4'd4;
	localparam kind_t KIND_ASSIGN   = 4'd5;
	localparam kind_t KIND_PLUS     = 4'd6;
	localparam kind_t KIND_MINUS    = 4'd7;
	localparam kind_t KIND_EOF      = 4'd8;
	localparam kind_t KIND_FUNCTION = 4'd9;
	localparam kind_t KIND_IF       = 4'd10;
	localparam kind_t KIND_ELSE     = 4'd11;
	localparam kind_t KIND_RETURN   = 4'd12;
	localparam kind_t KIND_IDENT    = 4'd13;
	localparam kind_t KIND_INT      = 4'd14;
	localparam kind_t KIND_ERROR    = 4'd15;

	// packed token: kind, line, begin col, end col, begin off, end off, value, last
	function automatic int unsigned token_width(input int unsigned pb, input int unsigned ob);
		return KIND_BITS + 3 * pb + 2 * ob + VALUE_BITS + 1;
	endfunction

endpackage

// ===== hdl/tks_fifo.sv =====
// small token result buffer: up to two writes per cycle, one read
// generic in width and depth (depth a power of two); no package use
`timescale 1ns / 1ps

module tks_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 push_count,
	input  logic [WIDTH-1:0]           push_data0,
	input  logic [WIDTH-1:0]           push_data1,
	input  logic                       pop,
	output logic [WIDTH-1:0]           head_data,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] fill
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [PTR_W-1:0] wr_ptr_next1;

	assign wr_ptr_next1 = wr_ptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			entry_q[wr_ptr_q] <= push_data0;
		end
		if (push_count == 2'd2) begin
			entry_q[wr_ptr_next1] <= push_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_q + CNT_W'(push_count) - CNT_W'(pop);
		end
	end

	assign head_data = entry_q[rd_ptr_q];
	assign empty     = (fill_q == '0);
	assign fill      = fill_q;

endmodule

// ===== hdl/tks_core.sv =====
// scanner state and per-character token logic, one character per enabled cycle
// depends on tks_pkg
`timescale 1ns / 1ps

module tks_core #(
	parameter int unsigned POSITION_BITS = tks_pkg::POSITION_BITS_DEF,
	parameter int unsigned OFFSET_BITS   = tks_pkg::OFFSET_BITS_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  enable,
	input  logic [7:0]                                            char_code,
	output logic [1:0]                                            tok_count,
	output logic [tks_pkg::token_width(POSITION_BITS, OFFSET_BITS)-1:0] tok0,
	output logic [tks_pkg::token_width(POSITION_BITS, OFFSET_BITS)-1:0] tok1
);

	import tks_pkg::*;

	localparam int unsigned PB = POSITION_BITS;
	localparam int unsigned OB = OFFSET_BITS;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [7:0] KW_TEXT [4][8] = '{
		'{"f", "u", "n", "c", "t", "i", "o", "n"},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
	};
	localparam logic [3:0] KW_LEN [4] = '{4'd8, 4'd2, 4'd4, 4'd6};

	run_mode_t       mode_q, mode_d;
	logic [3:0]      kw_q, kw_d;
	logic [3:0]      len_q, len_d;
	logic [PB-1:0]   line_q, line_d;
	logic [PB-1:0]   col_q, col_d;
	logic [OB-1:0]   off_q, off_d;
	logic [PB-1:0]   rbcol_q, rbcol_d;
	logic [OB-1:0]   rboff_q, rboff_d;
	logic [31:0]     acc_q, acc_d;

	logic            is_lower, is_digit, is_ws, is_nul, is_other;
	logic            close_word, close_num, start_run, run_tok_v;
	run_mode_t       mode_eff;
	logic [3:0]      kw_base, len_base;
	logic [31:0]     acc_base;
	logic [PB-1:0]   col_inc, line_inc;
	logic [OB-1:0]   off_inc;
	kind_t           run_kind, char_kind, punct_kind;
	logic [31:0]     run_val;
	logic [PB-1:0]   char_ecol;
	logic [OB-1:0]   char_eoff;
	logic [tks_pkg::token_width(PB, OB)-1:0] run_tok, char_tok;

	assign is_lower = (char_code >= "a") && (char_code <= "z");
	assign is_digit = (char_code >= "0") && (char_code <= "9");
	assign is_ws    = (char_code == CH_SPACE) || (char_code == CH_CR) ||
	                  (char_code == CH_LF) || (char_code == CH_TAB);
	assign is_nul   = (char_code == CH_NUL);
	assign is_other = !is_lower && !is_digit && !is_ws && !is_nul;

	assign col_inc  = (&col_q) ? col_q : col_q + PB'(1);
	assign line_inc = (&line_q) ? line_q : line_q + PB'(1);
	assign off_inc  = off_q + OB'(1);

	assign close_word = (mode_q == MODE_WORD) && !is_lower;
	assign close_num  = (mode_q == MODE_NUM) && !is_digit;
	assign run_tok_v  = close_word || close_num;

	// a closed run, or the unused mode code, drops back to idle
	always_comb begin
		if (run_tok_v || (mode_q != MODE_WORD && mode_q != MODE_NUM)) begin
			mode_eff = MODE_IDLE;
		end else begin
			mode_eff = mode_q;
		end
	end

	// keyword only when followed by whitespace or end of input
	always_comb begin
		run_kind = KIND_IDENT;
		if (close_num) begin
			run_kind = KIND_INT;
		end else if (is_ws || is_nul) begin
			priority if (kw_q[0] && len_q == KW_LEN[0]) begin
				run_kind = KIND_FUNCTION;
			end else if (kw_q[1] && len_q == KW_LEN[1]) begin
				run_kind = KIND_IF;
			end else if (kw_q[2] && len_q == KW_LEN[2]) begin
				run_kind = KIND_ELSE;
			end else if (kw_q[3] && len_q == KW_LEN[3]) begin
				run_kind = KIND_RETURN;
			end else begin
				run_kind = KIND_IDENT;
			end
		end
	end

	always_comb begin
		unique case (char_code)
			";":     punct_kind = KIND_SEMI;
			"{":     punct_kind = KIND_LBRACE;
			"}":     punct_kind = KIND_RBRACE;
			"(":     punct_kind = KIND_LPAREN;
			")":     punct_kind = KIND_RPAREN;
			"=":     punct_kind = KIND_ASSIGN;
			"+":     punct_kind = KIND_PLUS;
			"-":     punct_kind = KIND_MINUS;
			default: punct_kind = KIND_ERROR;
		endcase
	end

	assign run_val   = close_num ? acc_q : 32'd0;
	assign char_kind = is_nul ? KIND_EOF : punct_kind;
	assign char_ecol = is_nul ? col_q : col_inc;
	assign char_eoff = is_nul ? off_q : off_inc;

	assign run_tok  = {run_kind, line_q, rbcol_q, col_q, rboff_q, off_q, run_val, 1'b0};
	assign char_tok = {char_kind, line_q, col_q, char_ecol, off_q, char_eoff, 32'd0, 1'b1};

	always_comb begin
		tok0 = run_tok_v ? run_tok : char_tok;
		tok1 = char_tok;
		if (!(is_nul || is_other)) begin
			tok0[0] = 1'b1;
		end
		if (!enable) begin
			tok_count = 2'd0;
		end else begin
			tok_count = 2'(run_tok_v) + 2'(is_nul || is_other);
		end
	end

	// run bookkeeping and position update
	always_comb begin
		start_run = (is_lower && mode_eff != MODE_WORD) || (is_digit && mode_eff != MODE_NUM);
		kw_base   = start_run ? 4'hF : kw_q;
		len_base  = start_run ? 4'd0 : len_q;
		acc_base  = start_run ? 32'd0 : acc_q;

		mode_d  = MODE_IDLE;
		kw_d    = kw_q;
		len_d   = len_q;
		acc_d   = acc_q;
		rbcol_d = start_run ? col_q : rbcol_q;
		rboff_d = start_run ? off_q : rboff_q;
		line_d  = line_q;
		col_d   = col_inc;
		off_d   = off_inc;

		if (is_lower) begin
			mode_d = MODE_WORD;
			for (int k = 0; k < 4; k++) begin
				kw_d[k] = kw_base[k] && (len_base < KW_LEN[k]) &&
				          (KW_TEXT[k][len_base[2:0]] == char_code);
			end
		end else if (is_digit) begin
			mode_d = MODE_NUM;
			acc_d  = {acc_base[28:0], 3'b000} + {acc_base[30:0], 1'b0} +
			         {28'd0, 4'(char_code - CH_ZERO)};
		end

		if (is_lower || is_digit) begin
			len_d = (len_base == 4'd15) ? len_base : len_base + 4'd1;
		end

		if (is_nul) begin
			col_d = col_q;
			off_d = off_q;
		end else if (char_code == CH_LF) begin
			line_d = line_inc;
			col_d  = PB'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			kw_q    <= 4'hF;
			len_q   <= 4'd0;
			line_q  <= PB'(1);
			col_q   <= PB'(1);
			off_q   <= '0;
			rbcol_q <= PB'(1);
			rboff_q <= '0;
			acc_q   <= '0;
		end else if (enable) begin
			mode_q  <= mode_d;
			kw_q    <= kw_d;
			len_q   <= len_d;
			line_q  <= line_d;
			col_q   <= col_d;
			off_q   <= off_d;
			rbcol_q <= rbcol_d;
			rboff_q <= rboff_d;
			acc_q   <= acc_d;
		end
	end

endmodule

// ===== hdl/token_scanner.sv =====
// token scanner top level: input register, scanner core, token result buffer
// depends on tks_pkg, tks_core and tks_fifo
`timescale 1ns / 1ps

// Streaming tokenizer: one source byte per request on char_code (0 is end of
// input), tokens out one per request with line, columns, offsets and, for
// integers, the wrapped 32-bit value. A byte is taken every cycle unless the
// input stalls; an accepted byte waits in the input register until the scanner
// handles it, and its tokens pass through the result buffer to the output. A
// byte that closes a run and is itself a punctuator, error or end of input
// gives two tokens, which the output, one token per cycle when not stalled,
// delivers one after the other. The 4-entry result buffer lets input continue
// while the output is stalled, and the input stalls once fewer than two buffer
// entries are free. No clearing pass after reset.

module token_scanner #(
	parameter int unsigned POSITION_BITS = tks_pkg::POSITION_BITS_DEF,
	parameter int unsigned OFFSET_BITS   = tks_pkg::OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    char_code,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tks_pkg::KIND_BITS-1:0] token_kind,
	output logic [POSITION_BITS-1:0]      token_line,
	output logic [POSITION_BITS-1:0]      begin_column,
	output logic [POSITION_BITS-1:0]      end_column,
	output logic [OFFSET_BITS-1:0]        begin_offset,
	output logic [OFFSET_BITS-1:0]        end_offset,
	output logic signed [31:0]            int_value,
	output logic                          last
);

	import tks_pkg::*;

	localparam int unsigned TOK_W = token_width(POSITION_BITS, OFFSET_BITS);
	localparam int unsigned DEPTH = TOKEN_FIFO_DEPTH;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             go;
	logic [1:0]       tok_count;
	logic [TOK_W-1:0] tok0, tok1, head;
	logic             empty;
	logic [CNT_W-1:0] fill;

	// room for the worst case of two tokens per byte
	assign go       = valid_s1 && (fill <= CNT_W'(DEPTH - 2));
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
		end
	end

	tks_core #(
		.POSITION_BITS(POSITION_BITS),
		.OFFSET_BITS  (OFFSET_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (go),
		.char_code(char_s1),
		.tok_count(tok_count),
		.tok0     (tok0),
		.tok1     (tok1)
	);

	tks_fifo #(
		.WIDTH(TOK_W),
		.DEPTH(DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_count(tok_count),
		.push_data0(tok0),
		.push_data1(tok1),
		.pop       (out_valid && !out_stall),
		.head_data (head),
		.empty     (empty),
		.fill      (fill)
	);

	assign out_valid = !empty;
	assign {token_kind, token_line, begin_column, end_column,
	        begin_offset, end_offset, int_value, last} = head;

endmodule

// ===== tb/sv/token_scanner_checker.sv =====
// token scanner checker: follows both request channels, predicts tokens per source byte
// and compares them in order with what the scanner delivers
// depends on tks_pkg
`timescale 1ns / 1ps

module token_scanner_checker #(
	parameter int unsigned POS_W = tks_pkg::POSITION_BITS_DEF,
	parameter int unsigned OFF_W = tks_pkg::OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [7:0]                    char_code,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [tks_pkg::KIND_BITS-1:0] token_kind,
	input  logic [POS_W-1:0]              token_line,
	input  logic [POS_W-1:0]              begin_column,
	input  logic [POS_W-1:0]              end_column,
	input  logic [OFF_W-1:0]              begin_offset,
	input  logic [OFF_W-1:0]              end_offset,
	input  logic signed [31:0]            int_value,
	input  logic                          last,
	output int                            mismatches,
	output int                            outstanding
);
	import tks_pkg::*;

	localparam logic [7:0] CH_EOI = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	typedef struct packed {
		kind_t            kind;
		logic [POS_W-1:0] line_no;
		logic [POS_W-1:0] col_begin;
		logic [POS_W-1:0] col_end;
		logic [OFF_W-1:0] off_begin;
		logic [OFF_W-1:0] off_end;
		logic [31:0]      value;
		logic             is_last;
	} token_t;

	token_t expected_tokens[$];
	int fail_total;

	// scanner state as predicted
	run_mode_t        mode;
	logic [3:0]       kw_live;
	logic [3:0]       run_len;
	logic [POS_W-1:0] line_no;
	logic [POS_W-1:0] col_no;
	logic [POS_W-1:0] run_col;
	logic [OFF_W-1:0] offs;
	logic [OFF_W-1:0] run_off;
	logic [31:0]      acc;

	function automatic logic [POS_W-1:0] pos_step(input logic [POS_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic string kw_text(input int k);
		case (k)
			0:       return "function";
			1:       return "if";
			2:       return "else";
			default: return "return";
		endcase
	endfunction

	function automatic kind_t kw_kind(input int k);
		case (k)
			0:       return KIND_FUNCTION;
			1:       return KIND_IF;
			2:       return KIND_ELSE;
			default: return KIND_RETURN;
		endcase
	endfunction

	function automatic kind_t punct_kind(input logic [7:0] c);
		case (c)
			";":     return KIND_SEMI;
			"{":     return KIND_LBRACE;
			"}":     return KIND_RBRACE;
			"(":     return KIND_LPAREN;
			")":     return KIND_RPAREN;
			"=":     return KIND_ASSIGN;
			"+":     return KIND_PLUS;
			"-":     return KIND_MINUS;
			default: return KIND_ERROR;
		endcase
	endfunction

	function automatic string describe(input token_t t);
		return $sformatf("kind %0d line %0d col %0d..%0d off %0d..%0d value %0d last %0b",
			t.kind, t.line_no, t.col_begin, t.col_end, t.off_begin, t.off_end,
			$signed(t.value), t.is_last);
	endfunction

	task automatic emit_token(input kind_t kind, input logic [POS_W-1:0] cb,
			input logic [POS_W-1:0] ce, input logic [OFF_W-1:0] ob,
			input logic [OFF_W-1:0] oe, input logic [31:0] val);
		token_t t;
		t = {kind, line_no, cb, ce, ob, oe, val, 1'b0};
		expected_tokens.push_back(t);
	endtask

	task automatic step_position();
		col_no = pos_step(col_no);
		offs = offs + 1'b1;
	endtask

	task automatic open_run(input run_mode_t m);
		mode = m;
		kw_live = 4'hF;
		run_len = '0;
		acc = '0;
		run_col = col_no;
		run_off = offs;
	endtask

	task automatic scan_char(input logic [7:0] c);
		logic is_lower, is_digit, is_space;
		kind_t kind;
		string word;
		token_t t;
		int first, k;
		first = expected_tokens.size();
		is_lower = c >= "a" && c <= "z";
		is_digit = c >= "0" && c <= "9";
		is_space = c == " " || c == CH_CR || c == CH_LF || c == CH_TAB;

		// a byte that ends a run closes it first
		if (mode == MODE_WORD && !is_lower) begin
			kind = KIND_IDENT;
			if (is_space || c == CH_EOI) begin
				for (k = 0; k < 4; k++) begin
					word = kw_text(k);
					if (kind == KIND_IDENT && kw_live[k] && word.len() == run_len)
						kind = kw_kind(k);
				end
			end
			emit_token(kind, run_col, col_no, run_off, offs, '0);
			mode = MODE_IDLE;
		end else if (mode == MODE_NUM && !is_digit) begin
			emit_token(KIND_INT, run_col, col_no, run_off, offs, acc);
			mode = MODE_IDLE;
		end

		if (c == CH_EOI) begin
			emit_token(KIND_EOF, col_no, col_no, offs, offs, '0);
		end else if (is_space) begin
			if (c == CH_LF) begin
				line_no = pos_step(line_no);
				col_no = 1;
				offs = offs + 1'b1;
			end else begin
				step_position();
			end
		end else if (is_lower) begin
			if (mode != MODE_WORD)
				open_run(MODE_WORD);
			for (k = 0; k < 4; k++) begin
				word = kw_text(k);
				if (run_len >= word.len())
					kw_live[k] = 1'b0;
				else if (word[run_len] != c)
					kw_live[k] = 1'b0;
			end
			if (run_len != 4'hF)
				run_len = run_len + 1'b1;
			step_position();
		end else if (is_digit) begin
			if (mode != MODE_NUM)
				open_run(MODE_NUM);
			acc = acc * 32'd10 + {24'd0, c - 8'h30};
			if (run_len != 4'hF)
				run_len = run_len + 1'b1;
			step_position();
		end else begin
			// punctuator or unknown byte, one column wide
			emit_token(punct_kind(c), col_no, pos_step(col_no), offs, offs + 1'b1, '0);
			step_position();
		end

		if (expected_tokens.size() > first) begin
			t = expected_tokens.pop_back();
			t.is_last = 1'b1;
			expected_tokens.push_back(t);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		token_t seen, want;
		if (!arst_n) begin
			mode = MODE_IDLE;
			kw_live = 4'hF;
			run_len = '0;
			line_no = 1;
			col_no = 1;
			offs = '0;
			run_col = 1;
			run_off = '0;
			acc = '0;
			expected_tokens.delete();
			fail_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// results of this edge never stem from the request taken at the same edge
			if (out_valid && !out_stall) begin
				seen = {token_kind, token_line, begin_column, end_column, begin_offset,
					end_offset, int_value, last};
				if (expected_tokens.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("unexpected token: %s", describe(seen));
				end else begin
					want = expected_tokens.pop_front();
					if (seen !== want) begin
						fail_total++;
						if (fail_total <= 10)
							$display("token differs\n  expected %s\n  actual   %s",
								describe(want), describe(seen));
					end
				end
			end
			if (in_valid && !in_stall)
				scan_char(char_code);
			mismatches <= fail_total;
			outstanding <= expected_tokens.size();
		end
	end

endmodule

// ===== tb/sv/token_scanner_tb.sv =====
// token scanner testbench top: clock, reset, source byte stimulus and output stall
// depends on tks_pkg, token_scanner and token_scanner_checker
`timescale 1ns / 1ps

module token_scanner_tb;
	import tks_pkg::*;

	localparam int ITEM_TARGET  = 1900;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [7:0] CH_EOI = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           char_code;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [KIND_BITS-1:0] token_kind;
	logic [15:0]          token_line;
	logic [15:0]          begin_column;
	logic [15:0]          end_column;
	logic [31:0]          begin_offset;
	logic [31:0]          end_offset;
	logic signed [31:0]   int_value;
	logic                 last;
	int                   mismatches;
	int                   outstanding;

	int items_sent  = 0;
	int quiet_cycles = 0;
	int stall_left  = 0;
	int stall_pick;
	bit gaps_on     = 1'b1;
	bit stalls_on   = 1'b1;

	token_scanner dut (.*);

	token_scanner_checker tok_check (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// output stall: mostly short bursts, now and then a long hold, some quiet stretches
	always @(negedge clk) begin
		if ($urandom_range(0, 299) == 0)
			stalls_on = !stalls_on;
		if (stall_left > 0) begin
			stall_left--;
		end else if (!stalls_on) begin
			out_stall <= 1'b0;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 60) begin
				out_stall <= 1'b0;
			end else if (stall_pick < 93) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(10, 40);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("token_scanner: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// called at a falling edge, returns at the falling edge after the request is taken
	task automatic send_char(input logic [7:0] c);
		int gap, pick;
		gap = 0;
		if (gaps_on) begin
			pick = $urandom_range(0, 99);
			if (pick >= 95)
				gap = $urandom_range(6, 30);
			else if (pick >= 65)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	function automatic logic [7:0] rand_space();
		case ($urandom_range(0, 3))
			0:       return " ";
			1:       return CH_TAB;
			2:       return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] rand_punct();
		string p;
		p = ";{}()=+-";
		return p[$urandom_range(0, 7)];
	endfunction

	function automatic logic [7:0] rand_letter();
		return 8'h61 + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	function automatic string keyword_text(input int k);
		case (k)
			0:       return "function";
			1:       return "if";
			2:       return "else";
			default: return "return";
		endcase
	endfunction

	// byte that follows a run: whitespace or end of input keeps a keyword, anything else spoils it
	task automatic end_run();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			send_char(rand_space());
		else if (pick < 65)
			send_char(CH_EOI);
		else if (pick < 85)
			send_char(rand_punct());
		else if (pick < 92)
			send_char(rand_letter());
		else
			send_char(8'($urandom_range(0, 255)));
	endtask

	task automatic random_piece();
		int pick;
		string word;
		if ($urandom_range(0, 49) == 0)
			gaps_on = !gaps_on;
		pick = $urandom_range(0, 99);
		if (pick < 16) begin
			word = keyword_text($urandom_range(0, 3));
			if ($urandom_range(0, 4) == 0)
				word = word.substr(0, word.len() - 2);
			else if ($urandom_range(0, 5) == 0)
				word = {word, word};
			send_text(word);
			end_run();
		end else if (pick < 32) begin
			repeat ($urandom_range(1, 18)) send_char(rand_letter());
			end_run();
		end else if (pick < 46) begin
			case ($urandom_range(0, 5))
				0:       send_text("4294967295");
				1:       send_text("4294967296");
				2:       send_text("2147483648");
				3:       send_text("99999999999999999");
				default: repeat ($urandom_range(1, 9)) send_char(rand_digit());
			endcase
			end_run();
		end else if (pick < 62) begin
			send_char(rand_punct());
		end else if (pick < 74) begin
			repeat ($urandom_range(1, 3)) send_char(rand_space());
		end else if (pick < 80) begin
			// letters and digits back to back split into separate tokens
			repeat ($urandom_range(1, 3)) send_char(rand_letter());
			repeat ($urandom_range(1, 3)) send_char(rand_digit());
			repeat ($urandom_range(0, 2)) send_char(rand_letter());
			end_run();
		end else if (pick < 82) begin
			send_char(CH_EOI);
		end else begin
			repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int base;
		in_valid = 1'b0;
		char_code = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		send_text("else");
		send_char(CH_TAB);
		send_text("if(ab12c;");
		send_char(8'hFF);
		send_char("A");
		send_char(8'h80);
		send_text("{}=+-)");
		send_char(CH_CR);
		send_char("x");
		send_char(CH_EOI);
		send_char(CH_EOI);
		send_char(CH_LF);
		drain_results();

		base = items_sent;
		while (items_sent < base + ITEM_TARGET / 2)
			random_piece();
		drain_results();
		while (items_sent < base + ITEM_TARGET)
			random_piece();

		repeat (40) random_piece();

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("token_scanner: match");
		else
			$display("token_scanner: mismatch");
		$finish;
	end

endmodule
